// ===== rtl/core/dlbc_pkg.sv =====
// Shared types, constants and helper functions for the LED bounce chaser.
package dlbc_pkg;

	localparam int unsigned PatW  = 6;
	localparam int unsigned LedW  = 4;
	localparam int unsigned ModeW = 3;
	localparam int unsigned CfgW  = 8;
	localparam int unsigned CfgIdxW = 2;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] RegSamplesPerWindow = 2'd0;
	localparam logic [CfgIdxW-1:0] RegPressThreshold   = 2'd1;
	localparam logic [CfgIdxW-1:0] RegWindowsPerStep   = 2'd2;

	localparam logic [CfgW-1:0] SamplesPerWindowRst = 8'd100;
	localparam logic [CfgW-1:0] PressThresholdRst   = 8'd70;
	localparam logic [CfgW-1:0] WindowsPerStepRst   = 8'd10;

	localparam logic [ModeW-1:0] ModeOne   = 3'd1;
	localparam logic [ModeW-1:0] ModeThree = 3'd3;
	localparam logic [ModeW-1:0] ModeFive  = 3'd5;
	localparam logic [ModeW-1:0] ModeCount = 3'd6;
	localparam logic [ModeW-1:0] ModeZero  = 3'd0;

	localparam logic [PatW-1:0] PatOneLo   = 6'b000001;
	localparam logic [PatW-1:0] PatOneHi   = 6'b100000;
	localparam logic [PatW-1:0] PatTwoLo   = 6'b000011;
	localparam logic [PatW-1:0] PatTwoHi   = 6'b110000;
	localparam logic [PatW-1:0] PatThreeLo = 6'b000111;
	localparam logic [PatW-1:0] PatThreeHi = 6'b111000;

	typedef struct packed {
		logic [CfgW-1:0] samples_per_window;
		logic [CfgW-1:0] press_threshold;
		logic [CfgW-1:0] windows_per_step;
	} cfg_t;

	// Events handed from the timing/debounce logic to the pattern logic.
	typedef struct packed {
		logic             step;     // first tick of a step period
		logic             advance;  // mode advances on this tick
		logic [ModeW-1:0] mode_cur; // mode before this tick
		logic [ModeW-1:0] mode_nxt; // mode after this tick
	} ev_t;

	// Low end pattern of a moving mode; zero for frozen modes.
	function automatic logic [PatW-1:0] pat_lo(input logic [ModeW-1:0] m);
		logic [PatW-1:0] r;
		r = '0;
		unique case (m)
			ModeOne:   r = PatOneLo;
			ModeThree: r = PatTwoLo;
			ModeFive:  r = PatThreeLo;
			default:   r = '0;
		endcase
		return r;
	endfunction

	// High end pattern of a moving mode; zero for frozen modes.
	function automatic logic [PatW-1:0] pat_hi(input logic [ModeW-1:0] m);
		logic [PatW-1:0] r;
		r = '0;
		unique case (m)
			ModeOne:   r = PatOneHi;
			ModeThree: r = PatTwoHi;
			ModeFive:  r = PatThreeHi;
			default:   r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/dlbc_sample_if.sv =====
// Input channel carrying one button sample per transaction.
interface dlbc_sample_if;
	logic valid;
	logic ready;
	logic button_level;

	modport source (output valid, output button_level, input ready);
	modport sink (input valid, input button_level, output ready);
endinterface

// ===== rtl/core/dlbc_result_if.sv =====
// Output channel carrying the LED drive bits and the mode per transaction.
interface dlbc_result_if;
	logic                      valid;
	logic                      ready;
	logic [dlbc_pkg::LedW-1:0]  led_bits;
	logic [dlbc_pkg::ModeW-1:0] mode;

	modport source (output valid, output led_bits, output mode, input ready);
	modport sink (input valid, input led_bits, input mode, output ready);
endinterface

// ===== rtl/core/dlbc_ctrl.sv =====
// Sample and window counters, debounce decision and mode register.
module dlbc_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic                       button_level,
	input  dlbc_pkg::cfg_t             cfg,
	output dlbc_pkg::ev_t              ev
);
	logic [dlbc_pkg::CfgW-1:0]  pressed_count_q;
	logic [dlbc_pkg::CfgW-1:0]  sample_index_q;
	logic [dlbc_pkg::CfgW-1:0]  window_index_q;
	logic                       released_q;
	logic [dlbc_pkg::ModeW-1:0] mode_q;

	logic [dlbc_pkg::CfgW-1:0]  count_inc;
	logic [dlbc_pkg::CfgW-1:0]  sample_inc;
	logic [dlbc_pkg::CfgW-1:0]  window_inc;
	logic                       window_end;
	logic                       window_pressed;
	logic                       advance;
	logic [dlbc_pkg::ModeW-1:0] mode_plus;
	logic [dlbc_pkg::ModeW-1:0] mode_d;

	always_comb begin
		count_inc = pressed_count_q;
		if (!button_level && pressed_count_q != {dlbc_pkg::CfgW{1'b1}}) begin
			count_inc = pressed_count_q + 1'b1;
		end
		sample_inc     = sample_index_q + 1'b1;
		window_inc     = window_index_q + 1'b1;
		window_end     = sample_inc >= cfg.samples_per_window;
		window_pressed = count_inc > cfg.press_threshold;
		advance        = window_end && !window_pressed && !released_q;
		mode_plus      = mode_q + 1'b1;
		mode_d         = mode_q;
		if (advance) begin
			mode_d = (mode_plus >= dlbc_pkg::ModeCount) ? dlbc_pkg::ModeZero : mode_plus;
		end
		ev.step     = (sample_index_q == '0) && (window_index_q == '0);
		ev.advance  = advance;
		ev.mode_cur = mode_q;
		ev.mode_nxt = mode_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_count_q <= '0;
			sample_index_q  <= '0;
			window_index_q  <= '0;
			released_q      <= 1'b1;
			mode_q          <= dlbc_pkg::ModeOne;
		end else if (accept) begin
			mode_q <= mode_d;
			if (window_end) begin
				pressed_count_q <= '0;
				sample_index_q  <= '0;
				window_index_q  <= (window_inc >= cfg.windows_per_step) ? '0 : window_inc;
				if (window_pressed) begin
					released_q <= 1'b0;
				end else if (!released_q) begin
					released_q <= 1'b1;
				end
			end else begin
				pressed_count_q <= count_inc;
				sample_index_q  <= sample_inc;
			end
		end
	end
endmodule

// ===== rtl/core/dlbc_pattern.sv =====
// Bouncing LED pattern, its direction and the latched display bits.
module dlbc_pattern (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  dlbc_pkg::ev_t             ev,
	output logic [dlbc_pkg::LedW-1:0] displayed_d
);
	logic [dlbc_pkg::PatW-1:0] pattern_q;
	logic                      move_right_q;
	logic [dlbc_pkg::LedW-1:0] displayed_q;

	logic [dlbc_pkg::PatW-1:0] lo;
	logic [dlbc_pkg::PatW-1:0] hi;
	logic                      moving;
	logic [dlbc_pkg::PatW-1:0] shifted;
	logic                      dir_shifted;
	logic [dlbc_pkg::PatW-1:0] pattern_d;
	logic                      move_right_d;

	always_comb begin
		lo          = dlbc_pkg::pat_lo(ev.mode_cur);
		hi          = dlbc_pkg::pat_hi(ev.mode_cur);
		moving      = ev.mode_cur[0];
		shifted     = pattern_q;
		dir_shifted = move_right_q;
		if (ev.step && moving) begin
			shifted = move_right_q ? {1'b0, pattern_q[dlbc_pkg::PatW-1:1]}
			                       : {pattern_q[dlbc_pkg::PatW-2:0], 1'b0};
			if (shifted == lo || shifted == hi) begin
				dir_shifted = !move_right_q;
			end
		end
		displayed_d = ev.step ? shifted[dlbc_pkg::LedW:1] : displayed_q;
		// Entering a moving mode reloads the pattern after any shift of this tick.
		pattern_d    = shifted;
		move_right_d = dir_shifted;
		if (ev.advance && ev.mode_nxt[0]) begin
			pattern_d    = dlbc_pkg::pat_lo(ev.mode_nxt);
			move_right_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q    <= dlbc_pkg::PatOneLo;
			move_right_q <= 1'b0;
			displayed_q  <= '0;
		end else if (accept) begin
			pattern_q    <= pattern_d;
			move_right_q <= move_right_d;
			displayed_q  <= displayed_d;
		end
	end
endmodule

// ===== rtl/core/debounced_led_bounce_chaser_unit.sv =====
// Top level of the debounced LED bounce chaser with its output register.
//
// Each transaction on sample_ch is one sample tick carrying the raw,
// active-low button level. Every accepted sample produces exactly one
// transaction on result_ch, carrying the four LED drive bits and the
// current mode, both taken after that tick's update.
// Samples are grouped into debounce windows; a released window after a
// pressed one steps the mode through 0 to 5. Odd modes bounce 1, 2 or 3 lit
// bits across a 6-bit pattern once per step period; even modes freeze it.
// The result of a sample accepted at one edge is offered on result_ch
// from the next edge onwards. Throughput is one sample per cycle while
// the receiver does not stall. All state updates happen in a single
// pass of short logic into the state registers and the output register.
// When the receiver stalls, the finished result is held in the output
// register and sample_ch.ready drops until it is taken; a new sample is
// accepted in the same cycle as the waiting result is taken.
// Reset (arst_n low) restores the register defaults (100, 70, 10), mode 1,
// a single lit bit moving left, all LEDs off and an empty output register.
// The configuration port is written through cfg_we, cfg_index and
// cfg_data, by the user only while the block is idle; nothing enforces it.
module debounced_led_bounce_chaser_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	dlbc_sample_if.sink                        sample_ch,
	dlbc_result_if.source                      result_ch,
	input  logic                               cfg_we,
	input  logic [dlbc_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [dlbc_pkg::CfgW-1:0]          cfg_data
);
	dlbc_pkg::cfg_t             cfg_q;
	dlbc_pkg::ev_t              ev;
	logic                       accept;
	logic [dlbc_pkg::LedW-1:0]  displayed_d;
	logic                       out_valid_q;
	logic [dlbc_pkg::LedW-1:0]  led_q;
	logic [dlbc_pkg::ModeW-1:0] mode_q;

	// The output register can take a new result when it is empty or its
	// content is being taken in this cycle.
	assign sample_ch.ready = !out_valid_q || result_ch.ready;
	assign accept          = sample_ch.valid && sample_ch.ready;

	assign result_ch.valid    = out_valid_q;
	assign result_ch.led_bits = led_q;
	assign result_ch.mode     = mode_q;

	// Configuration registers; writes to an index beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.samples_per_window <= dlbc_pkg::SamplesPerWindowRst;
			cfg_q.press_threshold    <= dlbc_pkg::PressThresholdRst;
			cfg_q.windows_per_step   <= dlbc_pkg::WindowsPerStepRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dlbc_pkg::RegSamplesPerWindow: cfg_q.samples_per_window <= cfg_data;
				dlbc_pkg::RegPressThreshold:   cfg_q.press_threshold    <= cfg_data;
				dlbc_pkg::RegWindowsPerStep:   cfg_q.windows_per_step   <= cfg_data;
				default: ;
			endcase
		end
	end

	dlbc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.button_level (sample_ch.button_level),
		.cfg          (cfg_q),
		.ev           (ev)
	);

	dlbc_pattern u_pattern (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.ev          (ev),
		.displayed_d (displayed_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload of the output register.
	always_ff @(posedge clk) begin
		if (accept) begin
			led_q  <= displayed_d;
			mode_q <= ev.mode_nxt;
		end
	end
endmodule
